// ----- design/erq_pkg.sv -----
`timescale 1ns / 1ps
package erq_pkg;
  localparam int unsigned DEVICES = 4;
  localparam int unsigned SLOTS = 8;
  localparam int unsigned DEV_W = 2;
  localparam int unsigned SLOT_W = $clog2(SLOTS + 1);
  localparam int unsigned SLOT_IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam logic [SLOT_W-1:0] NIL_LINK = SLOT_W'(SLOTS);

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_NO_SLOT  = 3'd3;
  localparam logic [2:0] ST_EMPTY    = 3'd4;

  localparam logic [2:0] REG_DEVICE_COUNT = 3'd0;
  localparam logic [2:0] REG_DEV0_SECTORS = 3'd1;
  localparam logic [2:0] REG_DEV1_SECTORS = 3'd2;
  localparam logic [2:0] REG_DEV2_SECTORS = 3'd3;
  localparam logic [2:0] REG_DEV3_SECTORS = 3'd4;

  localparam logic ACT_SUBMIT = 1'b0;

  typedef struct packed {
    logic              action;
    logic [DEV_W-1:0]  device;
    logic [31:0]       lba;
    logic [31:0]       sector_count;
    logic              is_write;
    logic [31:0]       buffer_handle;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [DEV_W-1:0]  out_device;
    logic [31:0]       out_lba;
    logic [31:0]       out_count;
    logic              out_write;
    logic [31:0]       out_buffer;
    logic [2:0]        slot_used;
    logic [31:0]       served_total;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input request
    logic check;      // evaluate submit checks and allocation
    logic walk_init;  // start the sorted walk at the queue head
    logic walk_step;  // advance one linked entry
    logic link;       // write the new entry into the queue
    logic pop;        // remove the head entry
    logic fail;       // form an error result with the given status
    logic [2:0] fail_status;
    logic done_ok_submit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_submit;
    logic sub_invalid;
    logic sub_range;
    logic pool_full;
    logic disp_invalid;
    logic queue_empty;
    logic walk_done;
  } stat_t;
endpackage

// ----- design/erq_if.sv -----
`timescale 1ns / 1ps
interface erq_req_if;
  import erq_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface erq_rsp_if;
  import erq_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/elevator_request_queue_top.sv -----
`timescale 1ns / 1ps
// Elevator request queue: one result per request. A dispatch or a rejected
// submit has its result decided in S_DECIDE; an accepted submit first walks
// the device's sorted linked list in S_WALK, one queued entry per cycle, over
// 0..SLOTS-1 queued entries, and is then linked in. The next request is
// taken once the result has been delivered.
module elevator_request_queue_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  erq_req_if.sink     req_if,
  erq_rsp_if.source   rsp_if
);
  import erq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  erq_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (req_if.valid),
    .in_ready_o (req_if.ready),
    .out_valid_o(rsp_if.valid),
    .out_ready_i(rsp_if.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  erq_datapath u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .req_i  (req_if.data),
    .cmd_i  (cmd),
    .stat_o (stat),
    .rsp_o  (rsp_if.data)
  );
endmodule

// ----- design/erq_datapath.sv -----
`timescale 1ns / 1ps
module erq_datapath (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [2:0]           cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  erq_pkg::req_t        req_i,
  input  erq_pkg::cmd_t        cmd_i,
  output erq_pkg::stat_t       stat_o,
  output erq_pkg::rsp_t        rsp_o
);
  import erq_pkg::*;

  logic [2:0]            dev_cnt_q;
  logic [31:0]           sectors_q [DEVICES];
  logic [SLOTS-1:0]      busy_q;
  logic [31:0]           lba_q [SLOTS];
  logic [31:0]           cnt_q [SLOTS];
  logic                  wr_q  [SLOTS];
  logic [31:0]           buf_q [SLOTS];
  logic [SLOT_W-1:0]     link_q [SLOTS];
  logic [SLOT_W-1:0]     head_q [DEVICES];
  logic [31:0]           served_q;
  req_t                  r_q;
  logic [SLOT_W-1:0]     prev_q, cur_q, free_q;
  logic [SLOT_W-1:0]     steps_q;
  rsp_t                  rsp_q;

  logic [SLOT_W-1:0]     free_d;
  rsp_t                  rsp_d;
  logic [32:0]           end_lba;
  logic [31:0]           size;
  logic [SLOT_IDX_W-1:0] cur_idx, free_idx, prev_idx, head_idx;
  logic                  dev_ok;

  assign dev_ok   = {2'b00, r_q.device} < 4'(DEVICES);
  assign size     = sectors_q[r_q.device];
  assign end_lba  = {1'b0, r_q.lba} + {1'b0, r_q.sector_count};
  assign cur_idx  = cur_q[SLOT_IDX_W-1:0];
  assign free_idx = free_q[SLOT_IDX_W-1:0];
  assign prev_idx = prev_q[SLOT_IDX_W-1:0];
  assign head_idx = head_q[r_q.device][SLOT_IDX_W-1:0];

  // Lowest free slot, priority encoded over the busy flags.
  always_comb begin
    free_d = NIL_LINK;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) free_d = SLOT_W'(i);
    end
  end

  always_comb begin
    stat_o.is_submit    = (r_q.action == ACT_SUBMIT);
    stat_o.sub_invalid  = ({1'b0, r_q.device} >= dev_cnt_q) || !dev_ok ||
                          (r_q.sector_count == '0) || (r_q.buffer_handle == '0);
    stat_o.sub_range    = (size != '0) && (end_lba > {1'b0, size});
    stat_o.pool_full    = (free_d == NIL_LINK);
    stat_o.disp_invalid = !dev_ok;
    stat_o.queue_empty  = (head_q[r_q.device] == NIL_LINK);
    stat_o.walk_done    = (cur_q == NIL_LINK) || (steps_q == NIL_LINK) ||
                          (lba_q[cur_idx] > r_q.lba);
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_cnt_q <= '0;
      for (int i = 0; i < DEVICES; i++) sectors_q[i] <= '0;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_DEVICE_COUNT) begin
        dev_cnt_q <= cfg_data_i[2:0];
      end else if (cfg_idx_i <= REG_DEV3_SECTORS) begin
        sectors_q[2'(cfg_idx_i - 3'd1)] <= cfg_data_i;
      end
    end
  end

  // Queue control state: busy flags, heads and served counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= '0;
      served_q <= '0;
      for (int i = 0; i < DEVICES; i++) head_q[i] <= NIL_LINK;
    end else begin
      if (cmd_i.link) begin
        busy_q[free_idx] <= 1'b1;
        if (prev_q == NIL_LINK) head_q[r_q.device] <= free_q;
      end
      if (cmd_i.pop) begin
        busy_q[head_idx]    <= 1'b0;
        head_q[r_q.device]  <= link_q[head_idx];
        served_q            <= served_q + 32'd1;
      end
    end
  end

  // Slot storage, request capture and walk registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) r_q <= req_i;
    if (cmd_i.check) free_q <= free_d;
    if (cmd_i.walk_init) begin
      prev_q  <= NIL_LINK;
      cur_q   <= head_q[r_q.device];
      steps_q <= '0;
    end
    if (cmd_i.walk_step) begin
      prev_q  <= cur_q;
      cur_q   <= link_q[cur_idx];
      steps_q <= steps_q + SLOT_W'(1);
    end
    if (cmd_i.link) begin
      lba_q[free_idx]  <= r_q.lba;
      cnt_q[free_idx]  <= r_q.sector_count;
      wr_q[free_idx]   <= r_q.is_write;
      buf_q[free_idx]  <= r_q.buffer_handle;
      link_q[free_idx] <= cur_q;
      if (prev_q != NIL_LINK) link_q[prev_idx] <= free_q;
    end
    if (cmd_i.pop) link_q[head_idx] <= NIL_LINK;
  end

  // Next result: error, accepted submit or dispatched entry.
  always_comb begin
    rsp_d = rsp_q;
    if (cmd_i.fail) begin
      rsp_d              = '0;
      rsp_d.status       = cmd_i.fail_status;
      rsp_d.out_device   = r_q.device;
      rsp_d.served_total = served_q;
    end else if (cmd_i.link) begin
      rsp_d              = '0;
      rsp_d.status       = ST_OK;
      rsp_d.out_device   = r_q.device;
      rsp_d.slot_used    = 3'(free_q);
      rsp_d.served_total = served_q;
    end else if (cmd_i.pop) begin
      rsp_d.status       = ST_OK;
      rsp_d.out_device   = r_q.device;
      rsp_d.out_lba      = lba_q[head_idx];
      rsp_d.out_count    = cnt_q[head_idx];
      rsp_d.out_write    = wr_q[head_idx];
      rsp_d.out_buffer   = buf_q[head_idx];
      rsp_d.slot_used    = 3'(head_q[r_q.device]);
      rsp_d.served_total = served_q + 32'd1;
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    rsp_q <= rsp_d;
  end

  assign rsp_o = rsp_q;
endmodule

// ----- design/erq_ctrl.sv -----
`timescale 1ns / 1ps
module erq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  erq_pkg::stat_t stat_i,
  output erq_pkg::cmd_t  cmd_o
);
  import erq_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DECIDE, S_WALK, S_OUT} state_e;
  state_e state_q;
  logic   out_valid_q;

  assign out_valid_o = out_valid_q;
  // A new request is taken only once the last result has been delivered.
  assign in_ready_o  = (state_q == S_IDLE) && !out_valid_q;

  always_comb begin
    cmd_o = '0;
    cmd_o.load = in_valid_i && in_ready_o;
    unique case (state_q)
      S_DECIDE: begin
        cmd_o.check = 1'b1;
        if (stat_i.is_submit) begin
          if (stat_i.sub_invalid) begin
            cmd_o.fail = 1'b1; cmd_o.fail_status = ST_INVALID;
          end else if (stat_i.sub_range) begin
            cmd_o.fail = 1'b1; cmd_o.fail_status = ST_RANGE;
          end else if (stat_i.pool_full) begin
            cmd_o.fail = 1'b1; cmd_o.fail_status = ST_NO_SLOT;
          end else begin
            cmd_o.walk_init = 1'b1;
          end
        end else if (stat_i.disp_invalid) begin
          cmd_o.fail = 1'b1; cmd_o.fail_status = ST_INVALID;
        end else if (stat_i.queue_empty) begin
          cmd_o.fail = 1'b1; cmd_o.fail_status = ST_EMPTY;
        end else begin
          cmd_o.pop = 1'b1;
        end
      end
      S_WALK: begin
        if (stat_i.walk_done) cmd_o.link = 1'b1;
        else cmd_o.walk_step = 1'b1;
        cmd_o.done_ok_submit = stat_i.walk_done;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE:   if (cmd_o.load) state_q <= S_DECIDE;
        S_DECIDE: begin
          if (cmd_o.walk_init) begin
            state_q <= S_WALK;
          end else begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        S_WALK: if (cmd_o.done_ok_submit) begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b1;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
